>>> sv/dsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCO setting package
// Shared constants, fixed-point model coefficients, command and status types
// for the oscillator setting solver.
// ----------------------------------------------------------------------------
package dsf_pkg;

    // Fraction bits of every log-domain value.
    localparam int FREQ_BITS = 16;

    localparam int KHZ_W     = 16;
    localparam int WORD_W    = 16;
    localparam int LW        = FREQ_BITS + 8;      // signed log-domain width
    localparam int MW        = 31;                 // Q1.30 mantissa
    localparam int PW        = 4;                  // integer part of log2
    localparam int CNT_W     = $clog2(FREQ_BITS);
    localparam int XW        = FREQ_BITS - 3;      // series argument width
    localparam int EW        = XW + 1;             // series sum width
    localparam int VW        = 2 * XW - FREQ_BITS; // product after scaling
    localparam int RS        = XW + 3;             // reciprocal shift
    localparam int DW        = EW + 5;             // divider remainder width
    localparam int QW        = 6;                  // quotient up to 32

    // Model coefficients in Q32, rounded to nearest into the working format.
    localparam longint Q32_A      = 64'sd1413661936;
    localparam longint Q32_B      = 64'sd13147133;
    localparam longint Q32_C      = 64'sd190481800;
    localparam longint Q32_LN2    = 64'sd2977044472;
    localparam longint Q32_LN1000 = 64'sd29668583021;
    localparam longint RND_QF     = 64'sd1 <<< (31 - FREQ_BITS);

    localparam longint A_QF      = (Q32_A + RND_QF) >>> (32 - FREQ_BITS);
    localparam longint B_QF      = (Q32_B + RND_QF) >>> (32 - FREQ_BITS);
    localparam longint C_QF      = (Q32_C + RND_QF) >>> (32 - FREQ_BITS);
    localparam longint LN1000_QF = (Q32_LN1000 + RND_QF) >>> (32 - FREQ_BITS);
    // Rounding bias for the range count, less the model at step four.
    localparam longint NUM_K     = A_QF / 2 - 16 * B_QF - 4 * C_QF;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL8   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL12  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAL16  = 3'd4;

    localparam logic [WORD_W-1:0] OFFSET_RESET = 16'hD9C9;

    // Targets that return a stored calibration word.
    localparam logic [KHZ_W-1:0] KHZ_ZERO = 16'd0;
    localparam logic [KHZ_W-1:0] KHZ_1M   = 16'd1000;
    localparam logic [KHZ_W-1:0] KHZ_8M   = 16'd8000;
    localparam logic [KHZ_W-1:0] KHZ_12M  = 16'd12000;
    localparam logic [KHZ_W-1:0] KHZ_16M  = 16'd16000;

    // Result source codes.
    localparam logic [1:0] SRC_MODEL   = 2'd0;
    localparam logic [1:0] SRC_CAL     = 2'd1;
    localparam logic [1:0] SRC_DEFAULT = 2'd2;

    localparam logic [2:0] STEP_MAX = 3'd7;
    localparam logic [3:0] RSEL_MAX = 4'd15;
    localparam logic [4:0] MOD_MAX  = 5'd31;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SPEC,
        OP_NORM,
        OP_LOG,
        OP_LN,
        OP_NUM,
        OP_RSEL,
        OP_SRCH,
        OP_EINIT,
        OP_EMUL,
        OP_EDIV,
        OP_DIVI,
        OP_DIVS,
        OP_FIN
    } dsf_op_t;

    typedef struct packed {
        dsf_op_t          op;
        logic [CNT_W-1:0] cnt;
        logic             sel;
    } dsf_cmd_t;

    typedef struct packed {
        logic special;
        logic rsel_go;
        logic exceed;
        logic d_zero;
        logic d_last;
    } dsf_stat_t;

    typedef struct packed {
        logic [3:0] range_select;
        logic [2:0] dco_step;
        logic [4:0] modulation;
        logic [1:0] source;
    } dsf_res_t;

    // Model term B*d*d + C*d for each step.
    function automatic logic signed [LW-1:0] step_qf(input logic [2:0] d);
        logic signed [LW-1:0] v;
        case (d)
            3'd0: v = '0;
            3'd1: v = LW'(B_QF * 1 + C_QF * 1);
            3'd2: v = LW'(B_QF * 4 + C_QF * 2);
            3'd3: v = LW'(B_QF * 9 + C_QF * 3);
            3'd4: v = LW'(B_QF * 16 + C_QF * 4);
            3'd5: v = LW'(B_QF * 25 + C_QF * 5);
            3'd6: v = LW'(B_QF * 36 + C_QF * 6);
            3'd7: v = LW'(B_QF * 49 + C_QF * 7);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Rounded-up reciprocal of the series divisor, scaled by 2^RS.
    function automatic logic [RS-1:0] recip(input logic [2:0] k);
        logic [RS-1:0] r;
        case (k)
            3'd2: r = RS'(((64'd1 << RS) + 1) / 2);
            3'd3: r = RS'(((64'd1 << RS) + 2) / 3);
            3'd4: r = RS'(((64'd1 << RS) + 3) / 4);
            3'd5: r = RS'(((64'd1 << RS) + 4) / 5);
            3'd6: r = RS'(((64'd1 << RS) + 5) / 6);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/dsf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCO setting controller
// Sequences the log, range count, step search, two exp series and the
// modulation divide, and hands results to the output register.
// ----------------------------------------------------------------------------
module dsf_ctrl
    import dsf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_free,
    output logic      out_load,
    input  dsf_stat_t stat,
    output dsf_cmd_t  cmd
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_CHECK = 14'b00000000000010,
        S_LOG   = 14'b00000000000100,
        S_LN    = 14'b00000000001000,
        S_NUM   = 14'b00000000010000,
        S_RSEL  = 14'b00000000100000,
        S_SRCH  = 14'b00000001000000,
        S_EINIT = 14'b00000010000000,
        S_EMUL  = 14'b00000100000000,
        S_EDIV  = 14'b00001000000000,
        S_DIVI  = 14'b00010000000000,
        S_DIVS  = 14'b00100000000000,
        S_FIN   = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pass_reg, pass_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pass_next  = pass_reg;
        cmd.op     = OP_NONE;
        cmd.cnt    = cnt_reg;
        cmd.sel    = pass_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.special)
                begin
                    cmd.op     = OP_SPEC;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_NORM;
                    cnt_next   = '0;
                    state_next = S_LOG;
                end
            end
            S_LOG:
            begin
                cmd.op = OP_LOG;
                if (cnt_reg == CNT_W'(FREQ_BITS - 1))
                    state_next = S_LN;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_LN:
            begin
                cmd.op     = OP_LN;
                state_next = S_NUM;
            end
            S_NUM:
            begin
                cmd.op     = OP_NUM;
                state_next = S_RSEL;
            end
            S_RSEL:
            begin
                if (stat.rsel_go)
                    cmd.op = OP_RSEL;
                else
                    state_next = S_SRCH;
            end
            S_SRCH:
            begin
                cmd.op = OP_SRCH;
                if (stat.exceed)
                begin
                    if (stat.d_zero)
                        state_next = S_DONE;
                    else
                    begin
                        pass_next  = 1'b0;
                        state_next = S_EINIT;
                    end
                end
                else if (stat.d_last)
                    state_next = S_DONE;
            end
            S_EINIT:
            begin
                cmd.op     = OP_EINIT;
                cnt_next   = CNT_W'(2);
                state_next = S_EMUL;
            end
            S_EMUL:
            begin
                cmd.op     = OP_EMUL;
                state_next = S_EDIV;
            end
            S_EDIV:
            begin
                cmd.op = OP_EDIV;
                if (cnt_reg == CNT_W'(6))
                begin
                    if (!pass_reg)
                    begin
                        pass_next  = 1'b1;
                        state_next = S_EINIT;
                    end
                    else
                        state_next = S_DIVI;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_EMUL;
                end
            end
            S_DIVI:
            begin
                cmd.op     = OP_DIVI;
                cnt_next   = CNT_W'(QW - 1);
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.op = OP_DIVS;
                if (cnt_reg == '0)
                    state_next = S_FIN;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_FIN:
            begin
                cmd.op     = OP_FIN;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pass_reg  <= pass_next;
        end
    end

endmodule

>>> sv/dsf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCO setting datapath
// Log by repeated squaring, range count, step search over the model,
// truncated exp series and a bit-serial modulation divide.
// ----------------------------------------------------------------------------
module dsf_dp
    import dsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dsf_cmd_t          cmd,
    input  logic [KHZ_W-1:0]  target_khz,
    input  logic [WORD_W-1:0] model_offset,
    input  logic [WORD_W-1:0] cal_word_1mhz,
    input  logic [WORD_W-1:0] cal_word_8mhz,
    input  logic [WORD_W-1:0] cal_word_12mhz,
    input  logic [WORD_W-1:0] cal_word_16mhz,
    output dsf_stat_t         stat,
    output dsf_res_t          res
);

    localparam logic signed [LW-1:0] A_L      = LW'(A_QF);
    localparam logic signed [LW-1:0] LN1000_L = LW'(LN1000_QF);
    localparam logic signed [LW-1:0] NUM_L    = LW'(NUM_K);

    logic [KHZ_W-1:0]       target_reg;
    logic [MW-1:0]          m_reg;
    logic [PW-1:0]          p_reg;
    logic [FREQ_BITS-1:0]   frac_reg;
    logic signed [LW-1:0]   lt_reg, rem_reg, base_reg, prev_reg;
    logic [3:0]             rsel_reg;
    logic [2:0]             d_reg;
    logic [XW-1:0]          x0_reg, x1_reg, x_reg, t_reg;
    logic [EW-1:0]          s_reg, e0_reg, e1_reg;
    logic [2*XW-1:0]        prod_reg;
    logic [DW-1:0]          drem_reg;
    logic [QW-1:0]          q_reg;
    dsf_res_t               res_reg;

    logic signed [LW-1:0]   off_qf;
    logic [PW-1:0]          p_norm;
    logic [MW-1:0]          m_norm;
    logic [2*MW-1:0]        sq;
    logic [31:0]            sq_sh;
    logic [LW+31:0]         ln_prod;
    logic signed [LW-1:0]   ln_val;
    logic signed [LW-1:0]   ml;
    logic                   exceed;
    logic [VW+RS-1:0]       qprod;
    logic [XW-1:0]          t_new;
    logic [EW-1:0]          s_new;
    logic [DW-1:0]          dvs;
    logic [WORD_W-1:0]      word;
    logic [4:0]             mod_val;

    assign off_qf = LW'($signed(model_offset)) <<< (FREQ_BITS - 12);

    // Leading one of the target.
    always_comb
    begin
        p_norm = '0;
        for (int i = 0; i < KHZ_W; i++)
        begin
            if (target_reg[i])
                p_norm = PW'(i);
        end
    end
    assign m_norm = MW'(target_reg) << (5'd30 - {1'b0, p_norm});

    // One squaring step of the mantissa.
    assign sq    = (2 * MW)'(m_reg) * (2 * MW)'(m_reg);
    assign sq_sh = sq[30 +: 32];

    // log2 times ln 2, rounded to nearest.
    assign ln_prod = (LW + 32)'({p_reg, frac_reg}) * (LW + 32)'(Q32_LN2)
                   + (LW + 32)'(64'h8000_0000);
    assign ln_val  = $signed(ln_prod[32 +: LW]);

    // Model log at the current step.
    assign ml     = base_reg + step_qf(d_reg);
    assign exceed = ml > lt_reg;

    // Series term: divide by k through a rounded-up reciprocal.
    assign qprod = (VW + RS)'(prod_reg[FREQ_BITS +: VW]) * (VW + RS)'(recip(cmd.cnt[2:0]));
    assign t_new = XW'(qprod[RS +: VW]);
    assign s_new = s_reg + EW'(t_new);

    assign dvs = DW'(e1_reg) << cmd.cnt;

    assign mod_val = (q_reg > QW'(MOD_MAX)) ? MOD_MAX : q_reg[4:0];

    // Calibration word for an exact target.
    always_comb
    begin
        case (target_reg)
            KHZ_ZERO: word = cal_word_1mhz;
            KHZ_1M:   word = cal_word_1mhz;
            KHZ_8M:   word = cal_word_8mhz;
            KHZ_12M:  word = cal_word_12mhz;
            default:  word = cal_word_16mhz;
        endcase
    end

    assign stat.special = (target_reg == KHZ_ZERO) || (target_reg == KHZ_1M)
                       || (target_reg == KHZ_8M) || (target_reg == KHZ_12M)
                       || (target_reg == KHZ_16M);
    assign stat.rsel_go = (rem_reg >= A_L) && (rsel_reg != RSEL_MAX);
    assign stat.exceed  = exceed;
    assign stat.d_zero  = (d_reg == 3'd0);
    assign stat.d_last  = (d_reg == STEP_MAX);

    assign res = res_reg;

    // Datapath registers, updated by the current operation.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                target_reg <= target_khz;
            end
            OP_SPEC:
            begin
                res_reg.range_select <= word[11:8];
                res_reg.dco_step     <= word[7:5];
                res_reg.modulation   <= word[4:0];
                res_reg.source       <= (target_reg == KHZ_ZERO) ? SRC_DEFAULT : SRC_CAL;
            end
            OP_NORM:
            begin
                p_reg    <= p_norm;
                m_reg    <= m_norm;
                frac_reg <= '0;
            end
            OP_LOG:
            begin
                if (sq_sh[31])
                    m_reg <= sq_sh[31:1];
                else
                    m_reg <= sq_sh[30:0];
                frac_reg <= {frac_reg[FREQ_BITS-2:0], sq_sh[31]};
            end
            OP_LN:
            begin
                lt_reg <= ln_val - LN1000_L;
            end
            OP_NUM:
            begin
                rem_reg  <= lt_reg - off_qf + NUM_L;
                base_reg <= off_qf;
                rsel_reg <= '0;
                d_reg    <= '0;
            end
            OP_RSEL:
            begin
                rem_reg  <= rem_reg - A_L;
                base_reg <= base_reg + A_L;
                rsel_reg <= rsel_reg + 1'b1;
            end
            OP_SRCH:
            begin
                if (exceed)
                begin
                    x0_reg <= XW'(lt_reg - prev_reg);
                    x1_reg <= XW'(ml - prev_reg);
                    if (d_reg == 3'd0)
                    begin
                        res_reg.range_select <= rsel_reg;
                        res_reg.dco_step     <= '0;
                        res_reg.modulation   <= '0;
                        res_reg.source       <= SRC_MODEL;
                    end
                end
                else if (d_reg == STEP_MAX)
                begin
                    res_reg.range_select <= rsel_reg;
                    res_reg.dco_step     <= STEP_MAX;
                    res_reg.modulation   <= '0;
                    res_reg.source       <= SRC_MODEL;
                end
                else
                begin
                    prev_reg <= ml;
                    d_reg    <= d_reg + 1'b1;
                end
            end
            OP_EINIT:
            begin
                x_reg <= cmd.sel ? x1_reg : x0_reg;
                t_reg <= cmd.sel ? x1_reg : x0_reg;
                s_reg <= EW'(cmd.sel ? x1_reg : x0_reg);
            end
            OP_EMUL:
            begin
                prod_reg <= (2 * XW)'(t_reg) * (2 * XW)'(x_reg);
            end
            OP_EDIV:
            begin
                t_reg <= t_new;
                s_reg <= s_new;
                if (cmd.cnt == CNT_W'(6))
                begin
                    if (cmd.sel)
                        e1_reg <= s_new;
                    else
                        e0_reg <= s_new;
                end
            end
            OP_DIVI:
            begin
                drem_reg <= {e0_reg, 5'b0};
                q_reg    <= '0;
            end
            OP_DIVS:
            begin
                if (drem_reg >= dvs)
                begin
                    drem_reg               <= drem_reg - dvs;
                    q_reg[cmd.cnt[2:0]]    <= 1'b1;
                end
            end
            OP_FIN:
            begin
                res_reg.range_select <= rsel_reg;
                res_reg.dco_step     <= d_reg - 3'd1;
                res_reg.modulation   <= mod_val;
                res_reg.source       <= SRC_MODEL;
            end
            default:
            begin
            end
        endcase
    end

    // Each series term stays at or below its argument.
    a_term_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMUL) |-> (t_reg <= x_reg))
        else $error("exp series term exceeds its argument");

    // The target lies below the next step, so the quotient cannot pass 32.
    a_num_le_den: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DIVI) |-> (e0_reg <= e1_reg))
        else $error("modulation numerator above denominator");

    // Step interval is wider than the target's distance above the lower step.
    a_x_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EINIT && cmd.sel) |-> (x1_reg > x0_reg))
        else $error("step interval not wider than target offset");

endmodule

>>> sv/dco_setting_from_frequency_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCO setting from frequency
// Turns a target frequency in kHz into range select, DCO step and modulation
// through a log-domain oscillator model, with calibration words for exact
// 1, 8, 12 and 16 MHz targets.
// ----------------------------------------------------------------------------
// One request is solved at a time. Zero and exact calibration targets go from
// the check state to the done state, which loads the output register once it
// is free. Other targets run a 16-step squaring loop for the logarithm, one
// range count per cycle up to 15, up to eight model steps, two exp series on
// one shared datapath, and a six-step modulation divide with a setup state
// before it and a finish state after it. The output register holds a
// finished result while the next request is accepted and solved.
// Configuration is written through the cfg channel, which is always ready;
// write it only while no request is in flight. Indexes beyond the last
// register are ignored.
module dco_setting_from_frequency_core
    import dsf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [KHZ_W-1:0]     target_khz,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           range_select,
    output logic [2:0]           dco_step,
    output logic [4:0]           modulation,
    output logic [1:0]           source,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    logic [WORD_W-1:0] model_offset_reg;
    logic [WORD_W-1:0] cal1_reg, cal8_reg, cal12_reg, cal16_reg;
    logic              out_valid_reg;
    dsf_res_t          out_reg;
    dsf_res_t          dp_res;
    dsf_cmd_t          cmd;
    dsf_stat_t         stat;
    logic              out_load;
    logic              out_free;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_offset_reg <= OFFSET_RESET;
            cal1_reg         <= '0;
            cal8_reg         <= '0;
            cal12_reg        <= '0;
            cal16_reg        <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_OFFSET: model_offset_reg <= cfg_data;
                REG_CAL1:   cal1_reg         <= cfg_data;
                REG_CAL8:   cal8_reg         <= cfg_data;
                REG_CAL12:  cal12_reg        <= cfg_data;
                REG_CAL16:  cal16_reg        <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Output register.
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= dp_res;
    end

    assign out_valid    = out_valid_reg;
    assign range_select = out_reg.range_select;
    assign dco_step     = out_reg.dco_step;
    assign modulation   = out_reg.modulation;
    assign source       = out_reg.source;

    dsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .out_load (out_load),
        .stat     (stat),
        .cmd      (cmd)
    );

    dsf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .target_khz     (target_khz),
        .model_offset   (model_offset_reg),
        .cal_word_1mhz  (cal1_reg),
        .cal_word_8mhz  (cal8_reg),
        .cal_word_12mhz (cal12_reg),
        .cal_word_16mhz (cal16_reg),
        .stat           (stat),
        .res            (dp_res)
    );

endmodule
